### src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the calculator RTL.
// ---------------------------------------------------------------------------
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/lc_pkg.sv
// ---------------------------------------------------------------------------
// lc_pkg
// Shared constants and controller/datapath handshake types for the
// left-to-right calculator.
// ---------------------------------------------------------------------------
package lc_pkg;

  localparam int DEFAULT_VALUE_WIDTH   = 64;
  localparam int DEFAULT_FRACTION_BITS = 24;
  localparam int CHAR_WIDTH            = 8;
  localparam int OUT_VALUE_WIDTH       = 64;
  localparam int STATUS_WIDTH          = 3;
  localparam int DIGIT_BASE            = 10;

  // Status codes.
  localparam logic [STATUS_WIDTH-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_DIV0     = 3'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_BADOP    = 3'd2;
  localparam logic [STATUS_WIDTH-1:0] ST_BADDIGIT = 3'd3;
  localparam logic [STATUS_WIDTH-1:0] ST_OVF      = 3'd4;

  // Pending operator codes.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // ASCII characters of interest.
  localparam logic [CHAR_WIDTH-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_WIDTH-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_WIDTH-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;          // capture the incoming item
    logic take;          // decode the captured character
    logic start;         // launch the iterative multiply/divide
    logic commit_short;  // apply a pending operation without the iterative unit
    logic commit_long;   // apply the multiply/divide result
    logic finish;        // load the result register and clear the state
  } lc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic apply_req;  // the decoded character needs the pending op applied
    logic last;       // the captured item closes the expression
    logic long_op;    // the pending operation needs the iterative unit
    logic busy;       // the iterative unit is working
    logic done;       // the iterative unit has a result this cycle
  } lc_stat_t;

endpackage

### src/lc_if.sv
// ---------------------------------------------------------------------------
// lc_if
// Valid/ready stream interfaces for character input and result output.
// ---------------------------------------------------------------------------
interface lc_in_if;
  import lc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CHAR_WIDTH-1:0] character;
  logic                  last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

interface lc_out_if;
  import lc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OUT_VALUE_WIDTH-1:0] value;
  logic [STATUS_WIDTH-1:0]    status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

### src/lc_ctrl.sv
// ---------------------------------------------------------------------------
// lc_ctrl
// Sequencing state machine: capture, decode, apply, wait, deliver.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output lc_pkg::lc_cmd_t  cmd,
  input  lc_pkg::lc_stat_t stat
);
  import lc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TAKE   = 3'd1;
  localparam logic [2:0] S_APPLY  = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd.take = 1'b1;
        if (stat.apply_req) begin
          state_nxt = S_APPLY;
        end else if (stat.last) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_APPLY: begin
        if (stat.long_op) begin
          cmd.start = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          cmd.commit_short = 1'b1;
          state_nxt        = stat.last ? S_FINISH : S_IDLE;
        end
      end
      S_WAIT: begin
        if (stat.done) begin
          cmd.commit_long = 1'b1;
          state_nxt       = stat.last ? S_FINISH : S_IDLE;
        end
      end
      S_FINISH: begin
        // The result register may still hold an untaken item.
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_IMPL(a_no_overwrite, cmd.finish, !out_valid_r || out_ready, "result overwritten")
  `ASSERT_IMPL(a_wait_has_work, state_r == S_WAIT, stat.busy || stat.done, "wait with idle unit")
  `ASSERT_NEXT(a_load_then_take, cmd.load, state_r == S_TAKE, "capture not followed by decode")

endmodule

### src/lc_muldiv.sv
// ---------------------------------------------------------------------------
// lc_muldiv
// Iterative fixed-point multiply (one bit per cycle, shift-add) and divide
// (one quotient bit per cycle, restoring), with a final saturation step.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lc_muldiv #(
  parameter int VALUE_WIDTH   = lc_pkg::DEFAULT_VALUE_WIDTH,
  parameter int FRACTION_BITS = lc_pkg::DEFAULT_FRACTION_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   is_div,
  input  logic [VALUE_WIDTH-1:0] a_in,   // signed total
  input  logic [VALUE_WIDTH-1:0] b_in,   // non-negative operand
  output logic                   busy,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] res,
  output logic                   ovf
);
  import lc_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int PW = 2 * W;
  localparam int QW = W + F;
  localparam int MW = (PW > QW) ? PW : QW;
  localparam int CW = $clog2(QW + 1);
  localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

  logic          run_r, fit_r, done_r;
  logic [CW-1:0] cnt_r;
  logic          div_r, neg_r;
  logic [W-1:0]  mb_r, rem_r, res_r;
  logic [PW-1:0] prod_r;
  logic [QW-1:0] nq_r;
  logic          ovf_r;

  logic [W-1:0]  ma;
  logic [W:0]    mul_sum;
  logic [W:0]    div_trial;
  logic          div_ge;
  logic [W:0]    div_diff;
  logic [MW-1:0] mag_full;
  logic [W-1:0]  lim, mag;
  logic          over;

  always_comb begin
    ma        = a_in[W-1] ? (~a_in + 1'b1) : a_in;
    mul_sum   = {1'b0, prod_r[PW-1:W]} + (prod_r[0] ? {1'b0, mb_r} : {(W+1){1'b0}});
    div_trial = {rem_r, nq_r[QW-1]};
    div_ge    = (div_trial >= {1'b0, mb_r});
    div_diff  = div_trial - {1'b0, mb_r};
    mag_full  = div_r ? MW'(nq_r) : MW'(prod_r >> F);
    lim       = neg_r ? LIM_NEG : LIM_POS;
    over      = (mag_full > MW'(lim));
    mag       = over ? lim : mag_full[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fit_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && (cnt_r == CW'(1))) begin
        run_r <= 1'b0;
        fit_r <= 1'b1;
      end else if (fit_r) begin
        fit_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r  <= is_div;
      neg_r  <= a_in[W-1];
      mb_r   <= b_in;
      prod_r <= {{W{1'b0}}, ma};
      nq_r   <= QW'(ma) << F;
      rem_r  <= '0;
      cnt_r  <= is_div ? CW'(QW) : CW'(W);
    end else if (run_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (div_r) begin
        rem_r <= div_ge ? div_diff[W-1:0] : div_trial[W-1:0];
        nq_r  <= {nq_r[QW-2:0], div_ge};
      end else begin
        prod_r <= {mul_sum, prod_r[W-1:1]};
      end
    end
    if (fit_r) begin
      res_r <= neg_r ? (~mag + 1'b1) : mag;
      ovf_r <= over;
    end
  end

  assign busy = run_r | fit_r;
  assign done = done_r;
  assign res  = res_r;
  assign ovf  = ovf_r;

  `ASSERT_IMPL(a_start_when_free, start, !run_r && !fit_r && !done_r, "start while busy")
  `ASSERT_NEXT(a_done_pulse, done_r, !done_r && !run_r, "done held or unit restarted")

endmodule

### src/lc_dpath.sv
// ---------------------------------------------------------------------------
// lc_dpath
// Calculator datapath: character decode, operand build, running total,
// sticky status and the result register.
// ---------------------------------------------------------------------------
module lc_dpath #(
  parameter int VALUE_WIDTH   = lc_pkg::DEFAULT_VALUE_WIDTH,
  parameter int FRACTION_BITS = lc_pkg::DEFAULT_FRACTION_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [lc_pkg::CHAR_WIDTH-1:0]          in_character,
  input  logic                                   in_last,
  input  lc_pkg::lc_cmd_t                        cmd,
  output lc_pkg::lc_stat_t                       stat,
  output logic [lc_pkg::OUT_VALUE_WIDTH-1:0]     out_value,
  output logic [lc_pkg::STATUS_WIDTH-1:0]        out_status
);
  import lc_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int DW = W + F + 5;
  localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

  function automatic logic [STATUS_WIDTH-1:0] flagged(
    input logic [STATUS_WIDTH-1:0] cur,
    input logic [STATUS_WIDTH-1:0] code
  );
    return (cur == ST_OK) ? code : cur;
  endfunction

  logic [CHAR_WIDTH-1:0]      char_r;
  logic                       last_r;
  logic [W-1:0]               total_r, opnd_r;
  logic [1:0]                 pend_r, newop_r;
  logic                       first_r, need_r, endbad_r;
  logic [STATUS_WIDTH-1:0]    stat_r;
  logic [OUT_VALUE_WIDTH-1:0] out_value_r;
  logic [STATUS_WIDTH-1:0]    out_status_r;

  logic                       is_nul, is_digit, is_op, take_op, need_after;
  logic [3:0]                 digit_val;
  logic [DW-1:0]              digit_sum;
  logic                       digit_ovf;
  logic [1:0]                 op_code;
  logic [W:0]                 as_sum;
  logic                       as_ovf;
  logic [W-1:0]               as_res;
  logic                       md_busy, md_done, md_ovf;
  logic [W-1:0]               md_res;

  // Character decode against the state left by earlier characters.
  always_comb begin
    is_nul     = (char_r == CH_NUL);
    is_digit   = char_r inside {[CH_ZERO:CH_NINE]};
    is_op      = char_r inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    take_op    = !is_nul && !is_digit && !need_r && is_op;
    need_after = is_digit ? 1'b0 : (take_op ? 1'b1 : need_r);
    digit_val  = 4'(char_r - CH_ZERO);
    digit_sum  = DW'(opnd_r) * DW'(DIGIT_BASE) + (DW'(digit_val) << F);
    digit_ovf  = |digit_sum[DW-1:W-1];
    case (char_r)
      CH_PLUS:  op_code = OP_ADD;
      CH_MINUS: op_code = OP_SUB;
      CH_STAR:  op_code = OP_MUL;
      default:  op_code = OP_DIV;
    endcase
  end

  // Saturating add or subtract of the non-negative operand.
  always_comb begin
    if (pend_r == OP_SUB) begin
      as_sum = {total_r[W-1], total_r} - {1'b0, opnd_r};
    end else begin
      as_sum = {total_r[W-1], total_r} + {1'b0, opnd_r};
    end
    as_ovf = (as_sum[W] != as_sum[W-1]);
    as_res = as_ovf ? (as_sum[W] ? LIM_NEG : LIM_POS) : as_sum[W-1:0];
  end

  lc_muldiv #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start),
    .is_div(pend_r == OP_DIV),
    .a_in  (total_r),
    .b_in  (opnd_r),
    .busy  (md_busy),
    .done  (md_done),
    .res   (md_res),
    .ovf   (md_ovf)
  );

  always_comb begin
    stat.apply_req = take_op || (last_r && !need_after);
    stat.last      = last_r;
    stat.long_op   = !first_r && ((pend_r == OP_MUL) || ((pend_r == OP_DIV) && (|opnd_r)));
    stat.busy      = md_busy;
    stat.done      = md_done;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_r <= in_character;
      last_r <= in_last;
    end
    if (cmd.take) begin
      newop_r  <= op_code;
      endbad_r <= last_r && need_after;
    end
    if (cmd.finish) begin
      out_value_r  <= OUT_VALUE_WIDTH'($signed(total_r));
      out_status_r <= endbad_r ? flagged(stat_r, ST_BADDIGIT) : stat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.finish) begin
      total_r <= '0;
      opnd_r  <= '0;
      pend_r  <= OP_ADD;
      first_r <= 1'b1;
      need_r  <= 1'b1;
      stat_r  <= ST_OK;
    end else if (cmd.take) begin
      if (is_digit) begin
        opnd_r <= digit_ovf ? LIM_POS : digit_sum[W-1:0];
        need_r <= 1'b0;
        if (digit_ovf) begin
          stat_r <= flagged(stat_r, ST_OVF);
        end
      end else if (!is_nul && need_r) begin
        stat_r <= flagged(stat_r, ST_BADDIGIT);
      end else if (!is_nul && !is_op) begin
        stat_r <= flagged(stat_r, ST_BADOP);
      end
    end else if (cmd.commit_short || cmd.commit_long) begin
      if (cmd.commit_long) begin
        total_r <= md_res;
        if (md_ovf) begin
          stat_r <= flagged(stat_r, ST_OVF);
        end
      end else if (first_r) begin
        total_r <= opnd_r;
      end else if ((pend_r == OP_ADD) || (pend_r == OP_SUB)) begin
        total_r <= as_res;
        if (as_ovf) begin
          stat_r <= flagged(stat_r, ST_OVF);
        end
      end else begin
        // Division by zero keeps the total.
        stat_r <= flagged(stat_r, ST_DIV0);
      end
      pend_r  <= newop_r;
      opnd_r  <= '0;
      need_r  <= 1'b1;
      first_r <= 1'b0;
    end
  end

  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

### src/left_to_right_calculator.sv
// ---------------------------------------------------------------------------
// left_to_right_calculator
// Four-function calculator that evaluates an ASCII expression strictly left
// to right and returns a saturated signed fixed-point total with a status.
// ---------------------------------------------------------------------------
//
//   Channel      Dir  Payload               Item
//   in_stream    in   character[7:0], last  one character of the expression
//   out_stream   out  value[63:0], status   one result per expression
//
// A digit, a NUL or an error character is captured and decoded before the
// block is ready again. An operator that closes the first operand, an add or
// a subtract, or a divide by zero adds an apply step. A multiply or a divide
// also waits for the iterative unit, which works one bit per cycle and then
// saturates (the default format is Q39.24). The character that closes an
// expression adds a finish step that loads the result register. Reset is
// synchronous and active low; it clears the total, the operand and the
// status. While a result waits in the output register the block keeps
// taking characters, and it stalls only when a second result is ready
// before the first one has been taken.
// ---------------------------------------------------------------------------
module left_to_right_calculator #(
  parameter int VALUE_WIDTH   = lc_pkg::DEFAULT_VALUE_WIDTH,
  parameter int FRACTION_BITS = lc_pkg::DEFAULT_FRACTION_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  lc_in_if.sink    in_stream,
  lc_out_if.source out_stream
);
  import lc_pkg::*;

  lc_cmd_t  cmd;
  lc_stat_t stat;

  // The controller owns the handshakes and the sequence of steps for each
  // item; the datapath only acts on the command bits it receives.
  lc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_stream.valid),
    .in_ready (in_stream.ready),
    .out_valid(out_stream.valid),
    .out_ready(out_stream.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // The datapath holds the expression state and the result register, and
  // contains the shared iterative multiply/divide unit.
  lc_dpath #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_character(in_stream.character),
    .in_last     (in_stream.last),
    .cmd         (cmd),
    .stat        (stat),
    .out_value   (out_stream.value),
    .out_status  (out_stream.status)
  );

endmodule
